### rtl/assert_macros.svh
// Assertion macros for the checker file of the execute stage.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/iexs_pkg.sv
// Package for the integer execute stage: sizes, command codes, beat layout
// and the execute result record. Depends on nothing.
`default_nettype none

package iexs_pkg;

    localparam int XLEN       = 32;
    localparam int REG_COUNT  = 32;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int MEM_WORDS  = 1024;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int PROG_DEPTH = 1024;
    localparam int PC_W       = $clog2(PROG_DEPTH);
    localparam int CMD_W      = 5;
    localparam int TARGET_W   = 10;
    localparam int NEXT_PC_W  = 10;
    localparam int ADDR_OUT_W = 10;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 5'd0,
        CMD_SLT  = 5'd1,
        CMD_AND  = 5'd2,
        CMD_OR   = 5'd3,
        CMD_XOR  = 5'd4,
        CMD_SLL  = 5'd5,
        CMD_SRL  = 5'd6,
        CMD_SUB  = 5'd7,
        CMD_ADDI = 5'd8,
        CMD_SLTI = 5'd9,
        CMD_ANDI = 5'd10,
        CMD_ORI  = 5'd11,
        CMD_XORI = 5'd12,
        CMD_JALR = 5'd13,
        CMD_BEQ  = 5'd14,
        CMD_BNE  = 5'd15,
        CMD_BLT  = 5'd16,
        CMD_BGE  = 5'd17,
        CMD_JAL  = 5'd18,
        CMD_LI   = 5'd19,
        CMD_LW   = 5'd20,
        CMD_SW   = 5'd21,
        CMD_EXIT = 5'd22
    } cmd_t;

    // What one instruction does once its operands are known.
    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            halt;
        logic            wreg;
        logic [XLEN-1:0] wval;
        logic            is_load;
        logic            wmem;
        logic            access;
        logic [XLEN-1:0] addr;
        logic            bad;
    } exec_res_t;

endpackage

`default_nettype wire

### rtl/iexs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the register file copies and the data memory.
`default_nettype none

module iexs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wen,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     ren,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/iexs_exec.sv
// Execute logic: ALU, branch decision, jump targets and load/store address.
// Depends on iexs_pkg.
`default_nettype none

module iexs_exec (
    input  wire iexs_pkg::cmd_t                  cmd,
    input  wire logic [iexs_pkg::PC_W-1:0]       pc,
    input  wire logic                            halted,
    input  wire logic [iexs_pkg::XLEN-1:0]       op_a,
    input  wire logic [iexs_pkg::XLEN-1:0]       op_b,
    input  wire logic [iexs_pkg::XLEN-1:0]       imm,
    input  wire logic [iexs_pkg::TARGET_W-1:0]   target,
    output iexs_pkg::exec_res_t                  res
);
    import iexs_pkg::*;

    logic [XLEN-1:0] link;
    logic [XLEN-1:0] base;
    logic [XLEN-1:0] ea;
    logic [XLEN-1:0] jalr_sum;
    logic [PC_W-1:0] seq_pc;
    logic [PC_W-1:0] br_pc;
    logic            lt_ab;

    assign link     = XLEN'(pc) + XLEN'(1);
    assign seq_pc   = pc + PC_W'(1);
    assign br_pc    = PC_W'(target);
    assign lt_ab    = $signed(op_a) < $signed(op_b);
    assign jalr_sum = op_a + imm;
    assign base     = (cmd == CMD_SW) ? op_b : op_a;
    assign ea       = base + imm;

    always_comb
    begin
        res         = '0;
        res.next_pc = seq_pc;
        if (halted)
        begin
            res.next_pc = pc;
            res.halt    = 1'b1;
        end
        else
        begin
            case (cmd)
                CMD_ADD:  begin res.wval = op_a + op_b;  res.wreg = 1'b1; end
                CMD_SLT:  begin res.wval = XLEN'(lt_ab); res.wreg = 1'b1; end
                CMD_AND:  begin res.wval = op_a & op_b;  res.wreg = 1'b1; end
                CMD_OR:   begin res.wval = op_a | op_b;  res.wreg = 1'b1; end
                CMD_XOR:  begin res.wval = op_a ^ op_b;  res.wreg = 1'b1; end
                CMD_SLL:  begin res.wval = op_a << op_b[4:0]; res.wreg = 1'b1; end
                CMD_SRL:  begin res.wval = op_a >> op_b[4:0]; res.wreg = 1'b1; end
                CMD_SUB:  begin res.wval = op_a - op_b;  res.wreg = 1'b1; end
                CMD_ADDI: begin res.wval = jalr_sum;     res.wreg = 1'b1; end
                CMD_SLTI:
                begin
                    res.wval = XLEN'($signed(op_a) < $signed(imm));
                    res.wreg = 1'b1;
                end
                CMD_ANDI: begin res.wval = op_a & imm;   res.wreg = 1'b1; end
                CMD_ORI:  begin res.wval = op_a | imm;   res.wreg = 1'b1; end
                CMD_XORI: begin res.wval = op_a ^ imm;   res.wreg = 1'b1; end
                CMD_JALR:
                begin
                    res.wval    = link;
                    res.wreg    = 1'b1;
                    res.next_pc = jalr_sum[PC_W-1:0];
                end
                CMD_BEQ:  if (op_a == op_b) res.next_pc = br_pc;
                CMD_BNE:  if (op_a != op_b) res.next_pc = br_pc;
                CMD_BLT:  if (lt_ab) res.next_pc = br_pc;
                CMD_BGE:  if (!lt_ab) res.next_pc = br_pc;
                CMD_JAL:
                begin
                    res.wval    = link;
                    res.wreg    = 1'b1;
                    res.next_pc = pc + imm[PC_W-1:0];
                end
                CMD_LI:   begin res.wval = imm; res.wreg = 1'b1; end
                CMD_LW, CMD_SW:
                begin
                    res.access = 1'b1;
                    res.addr   = ea;
                    res.bad    = ea[XLEN-1] || (ea[XLEN-2:0] >= (XLEN-1)'(MEM_WORDS));
                    // The load value arrives from memory in the next cycle.
                    res.is_load = (cmd == CMD_LW) && !res.bad;
                    res.wreg    = res.is_load;
                    res.wmem    = (cmd == CMD_SW) && !res.bad;
                end
                CMD_EXIT:
                begin
                    res.halt    = 1'b1;
                    res.next_pc = pc;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/integer_execute_stage_top.sv
// Top level of the integer execute stage around two register file RAMs and one data RAM.
// Depends on iexs_pkg, iexs_ram and iexs_exec.
// An input beat passes the operand fetch, memory / write-back and output registers.
// Throughput: one instruction per cycle; a stalled output freezes the pipeline.
// Reset: control state clears at once, then a pass over every word zeroes the data
// RAM with s_axis_tready low; the register file reads as zero until written.
`default_nettype none

module integer_execute_stage_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // command[4:0], dest_reg[9:5], src_reg_a[14:10], src_reg_b[19:15],
    // immediate[51:20], branch_target[61:52], zero[63:62]
    input  wire logic [iexs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // next_pc[9:0], halted[10], reg_write[11], write_index[16:12],
    // write_value[48:17], mem_write[49], mem_address[59:50],
    // bad_address[60], zero[63:61]
    output logic      [iexs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import iexs_pkg::*;

    logic                  adv;
    logic                  accept;
    logic                  clearing;
    logic [MEM_AW:0]       clear_cnt_reg;

    // Operand fetch stage.
    logic                  s1_valid_reg;
    cmd_t                  s1_cmd_reg;
    logic [REG_AW-1:0]     s1_rd_reg;
    logic [REG_AW-1:0]     s1_ra_reg;
    logic [REG_AW-1:0]     s1_rb_reg;
    logic [XLEN-1:0]       s1_imm_reg;
    logic [TARGET_W-1:0]   s1_target_reg;

    // Memory / write-back stage.
    logic                  s2_valid_reg;
    logic [REG_AW-1:0]     s2_rd_reg;
    exec_res_t             s2_res_reg;

    // Last write-back, kept for the beat whose RAM read raced it.
    logic                  w3_valid_reg;
    logic [REG_AW-1:0]     w3_idx_reg;
    logic [XLEN-1:0]       w3_val_reg;

    logic [PC_W-1:0]       pc_reg;
    logic                  halt_reg;
    logic [REG_COUNT-1:0]  rf_valid_reg;
    logic [REG_COUNT-1:0]  rf_valid_next;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [XLEN-1:0]       rfa_rdata;
    logic [XLEN-1:0]       rfb_rdata;
    logic [XLEN-1:0]       dm_rdata;
    logic [XLEN-1:0]       op_a;
    logic [XLEN-1:0]       op_b;
    logic                  s2_wen;
    logic [XLEN-1:0]       s2_wval;
    exec_res_t             ex_res;

    logic                  dm_wen;
    logic [MEM_AW-1:0]     dm_waddr;
    logic [XLEN-1:0]       dm_wdata;

    assign clearing      = !clear_cnt_reg[MEM_AW];
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && !clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign s2_wen  = s2_valid_reg && s2_res_reg.wreg;
    assign s2_wval = s2_res_reg.is_load ? dm_rdata : s2_res_reg.wval;

    iexs_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .wen   (adv && s2_wen),
        .waddr (s2_rd_reg),
        .wdata (s2_wval),
        .ren   (adv),
        .raddr (s_axis_tdata[14:10]),
        .rdata (rfa_rdata)
    );

    iexs_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .wen   (adv && s2_wen),
        .waddr (s2_rd_reg),
        .wdata (s2_wval),
        .ren   (adv),
        .raddr (s_axis_tdata[19:15]),
        .rdata (rfb_rdata)
    );

    // Forwarding: the write-back stage first, then the last retired write.
    always_comb
    begin
        if (s2_wen && s2_rd_reg == s1_ra_reg)
        begin
            op_a = s2_wval;
        end
        else if (w3_valid_reg && w3_idx_reg == s1_ra_reg)
        begin
            op_a = w3_val_reg;
        end
        else
        begin
            op_a = rf_valid_reg[s1_ra_reg] ? rfa_rdata : '0;
        end

        if (s2_wen && s2_rd_reg == s1_rb_reg)
        begin
            op_b = s2_wval;
        end
        else if (w3_valid_reg && w3_idx_reg == s1_rb_reg)
        begin
            op_b = w3_val_reg;
        end
        else
        begin
            op_b = rf_valid_reg[s1_rb_reg] ? rfb_rdata : '0;
        end
    end

    iexs_exec u_exec (
        .cmd    (s1_cmd_reg),
        .pc     (pc_reg),
        .halted (halt_reg),
        .op_a   (op_a),
        .op_b   (op_b),
        .imm    (s1_imm_reg),
        .target (s1_target_reg),
        .res    (ex_res)
    );

    always_comb
    begin
        if (clearing)
        begin
            dm_wen   = 1'b1;
            dm_waddr = clear_cnt_reg[MEM_AW-1:0];
            dm_wdata = '0;
        end
        else
        begin
            dm_wen   = adv && s1_valid_reg && ex_res.wmem;
            dm_waddr = ex_res.addr[MEM_AW-1:0];
            dm_wdata = op_a;
        end
    end

    iexs_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_dmem (
        .clk   (clk),
        .wen   (dm_wen),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .ren   (adv),
        .raddr (ex_res.addr[MEM_AW-1:0]),
        .rdata (dm_rdata)
    );

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (adv && s2_wen)
        begin
            rf_valid_next[s2_rd_reg] = 1'b1;
        end
    end

    always_comb
    begin
        out_data_next          = '0;
        out_data_next[9:0]     = NEXT_PC_W'(s2_res_reg.next_pc);
        out_data_next[10]      = s2_res_reg.halt;
        out_data_next[11]      = s2_res_reg.wreg;
        out_data_next[16:12]   = s2_res_reg.wreg ? s2_rd_reg : '0;
        out_data_next[48:17]   = s2_res_reg.wreg ? s2_wval : '0;
        out_data_next[49]      = s2_res_reg.wmem;
        out_data_next[59:50]   = s2_res_reg.addr[ADDR_OUT_W-1:0];
        out_data_next[60]      = s2_res_reg.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            w3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clear_cnt_reg <= clear_cnt_reg + (MEM_AW+1)'(1);
            end
            rf_valid_reg <= rf_valid_next;
            if (adv)
            begin
                s1_valid_reg  <= accept;
                s2_valid_reg  <= s1_valid_reg;
                w3_valid_reg  <= s2_wen;
                out_valid_reg <= s2_valid_reg;
                if (s1_valid_reg)
                begin
                    pc_reg   <= ex_res.next_pc;
                    halt_reg <= ex_res.halt;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg    <= cmd_t'(s_axis_tdata[4:0]);
            s1_rd_reg     <= s_axis_tdata[9:5];
            s1_ra_reg     <= s_axis_tdata[14:10];
            s1_rb_reg     <= s_axis_tdata[19:15];
            s1_imm_reg    <= s_axis_tdata[51:20];
            s1_target_reg <= s_axis_tdata[61:52];
            s2_rd_reg     <= s1_rd_reg;
            s2_res_reg    <= ex_res;
            w3_idx_reg    <= s2_rd_reg;
            w3_val_reg    <= s2_wval;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

### rtl/iexs_checker.sv
// Port-level checker for the integer execute stage, bound to the top level.
// Depends on assert_macros.svh and integer_execute_stage_top.
`default_nettype none

`include "assert_macros.svh"

module iexs_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata
);

    logic saw_halt_reg;

    // Set once a halted beat has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_halt_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[10])
        begin
            saw_halt_reg <= 1'b1;
        end
    end

    `ASSERT_NEXT_CYCLE(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
    `ASSERT_SAME_CYCLE(a_halt_sticky, m_axis_tvalid && saw_halt_reg, m_axis_tdata[10] && !m_axis_tdata[11] && !m_axis_tdata[49], "activity after halt")
    `ASSERT_SAME_CYCLE(a_no_wb_zero, m_axis_tvalid && !m_axis_tdata[11], m_axis_tdata[48:12] == 37'd0, "write fields not zero without register write")
    `ASSERT_SAME_CYCLE(a_bad_no_write, m_axis_tvalid && m_axis_tdata[60], !m_axis_tdata[11] && !m_axis_tdata[49], "write despite bad address")

endmodule

bind integer_execute_stage_top iexs_checker u_iexs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for integer_execute_stage_top: directed and random instruction
// streams, with a predictor of the register file, data memory, program counter and halt.
// Depends on iexs_pkg and the execute stage RTL; it needs no other files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iexs_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 10;
    localparam longint TIMEOUT_NS = 64'd200_000 * CLK_PERIOD;
    localparam int GAP_MAX        = 10;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_ITEMS     = 40;
    localparam int HALTED_ITEMS   = 6;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 20;

    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 5'd23;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 5'd31;

    typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    // Fields of one instruction beat, lowest field last.
    typedef struct packed {
        logic [TARGET_W-1:0] branch_target;
        logic [XLEN-1:0]     immediate;
        logic [REG_AW-1:0]   src_reg_b;
        logic [REG_AW-1:0]   src_reg_a;
        logic [REG_AW-1:0]   dest_reg;
        logic [CMD_W-1:0]    command;
    } instr_t;

    // Fields of one retired-instruction beat, lowest field last.
    typedef struct packed {
        logic                  bad_address;
        logic [ADDR_OUT_W-1:0] mem_address;
        logic                  mem_write;
        logic [XLEN-1:0]       write_value;
        logic [REG_AW-1:0]     write_index;
        logic                  reg_write;
        logic                  halted;
        logic [NEXT_PC_W-1:0]  next_pc;
    } retire_t;

    localparam int INSTR_W  = $bits(instr_t);
    localparam int RETIRE_W = $bits(retire_t);

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Architectural state as the bench expects it to be.
    bit [XLEN-1:0] model_regs [REG_COUNT];
    bit [XLEN-1:0] model_mem  [MEM_WORDS];
    bit [PC_W-1:0] model_pc;
    bit            model_halt;

    retire_t retire_q [$];

    int error_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int taken_count   = 0;
    int load_count    = 0;
    int store_count   = 0;
    int bad_count     = 0;

    int         burst_left  = 0;
    int         burst_max   = 16;
    bit         stream_mode = 1'b0;
    sink_mode_t sink_mode   = SINK_RANDOM;
    int         hold_left   = 0;
    int         stall_left  = 0;
    int         sink_cycle  = 0;

    integer_execute_stage_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", retire_q.size());
        $display("testbench: FAIL");
        $finish;
    end

    // Executes one instruction on the expected state and returns what should retire.
    function automatic retire_t execute_instr(instr_t ins);
        retire_t         r;
        bit [XLEN-1:0]   a;
        bit [XLEN-1:0]   b;
        bit [XLEN-1:0]   imm;
        bit [XLEN-1:0]   wval;
        bit [XLEN-1:0]   sum;
        bit [PC_W-1:0]   this_index;
        bit [PC_W-1:0]   next_index;
        bit              wreg;
        bit              taken;
        r = '0;
        if (model_halt)
        begin
            r.next_pc = model_pc;
            r.halted  = 1'b1;
            return r;
        end
        this_index = model_pc;
        next_index = this_index + 1'b1;
        a     = model_regs[ins.src_reg_a];
        b     = model_regs[ins.src_reg_b];
        imm   = ins.immediate;
        wval  = '0;
        wreg  = 1'b0;
        taken = 1'b0;
        case (ins.command)
            CMD_ADD:  begin wval = a + b; wreg = 1'b1; end
            CMD_SLT:  begin wval = ($signed(a) < $signed(b)) ? 1 : 0; wreg = 1'b1; end
            CMD_AND:  begin wval = a & b; wreg = 1'b1; end
            CMD_OR:   begin wval = a | b; wreg = 1'b1; end
            CMD_XOR:  begin wval = a ^ b; wreg = 1'b1; end
            CMD_SLL:  begin wval = a << b[4:0]; wreg = 1'b1; end
            CMD_SRL:  begin wval = a >> b[4:0]; wreg = 1'b1; end
            CMD_SUB:  begin wval = a - b; wreg = 1'b1; end
            CMD_ADDI: begin wval = a + imm; wreg = 1'b1; end
            CMD_SLTI: begin wval = ($signed(a) < $signed(imm)) ? 1 : 0; wreg = 1'b1; end
            CMD_ANDI: begin wval = a & imm; wreg = 1'b1; end
            CMD_ORI:  begin wval = a | imm; wreg = 1'b1; end
            CMD_XORI: begin wval = a ^ imm; wreg = 1'b1; end
            CMD_JALR:
            begin
                // The link is not wrapped, so a jump from the top index links 1024.
                wval       = {{(XLEN-PC_W){1'b0}}, this_index} + 1;
                wreg       = 1'b1;
                sum        = a + imm;
                next_index = sum[PC_W-1:0];
            end
            CMD_BEQ:  taken = (a == b);
            CMD_BNE:  taken = (a != b);
            CMD_BLT:  taken = ($signed(a) < $signed(b));
            CMD_BGE:  taken = ($signed(a) >= $signed(b));
            CMD_JAL:
            begin
                wval       = {{(XLEN-PC_W){1'b0}}, this_index} + 1;
                wreg       = 1'b1;
                sum        = {{(XLEN-PC_W){1'b0}}, this_index} + imm;
                next_index = sum[PC_W-1:0];
            end
            CMD_LI:   begin wval = imm; wreg = 1'b1; end
            CMD_LW, CMD_SW:
            begin
                sum = ((ins.command == CMD_LW) ? a : b) + imm;
                r.mem_address = sum[ADDR_OUT_W-1:0];
                // Negative addresses are huge when read as unsigned, so one test covers both.
                r.bad_address = (sum >= MEM_WORDS);
                if (r.bad_address)
                    bad_count++;
                else if (ins.command == CMD_LW)
                begin
                    wval = model_mem[sum[MEM_AW-1:0]];
                    wreg = 1'b1;
                    load_count++;
                end
                else
                begin
                    model_mem[sum[MEM_AW-1:0]] = a;
                    r.mem_write = 1'b1;
                    store_count++;
                end
            end
            CMD_EXIT:
            begin
                model_halt = 1'b1;
                next_index = this_index;
            end
            default: ;
        endcase
        if (taken)
        begin
            next_index = ins.branch_target;
            taken_count++;
        end
        if (wreg)
        begin
            model_regs[ins.dest_reg] = wval;
            r.write_index = ins.dest_reg;
            r.write_value = wval;
        end
        r.reg_write = wreg;
        model_pc    = next_index;
        r.next_pc   = next_index;
        r.halted    = model_halt;
        return r;
    endfunction

    function automatic instr_t make_instr(logic [CMD_W-1:0] cmd, logic [REG_AW-1:0] rd,
                                          logic [REG_AW-1:0] ra, logic [REG_AW-1:0] rb,
                                          logic [XLEN-1:0] imm, logic [TARGET_W-1:0] target);
        instr_t ins;
        ins.command       = cmd;
        ins.dest_reg      = rd;
        ins.src_reg_a     = ra;
        ins.src_reg_b     = rb;
        ins.immediate     = imm;
        ins.branch_target = target;
        return ins;
    endfunction

    // Offset that takes the current value of a base register to a chosen word address.
    function automatic logic [XLEN-1:0] imm_to_reach(logic [REG_AW-1:0] base,
                                                     logic [XLEN-1:0] addr);
        return addr - model_regs[base];
    endfunction

    // Mostly a small set of registers, so that results are read back soon after.
    function automatic logic [REG_AW-1:0] pick_reg();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 7);
        return $urandom_range(0, REG_COUNT - 1);
    endfunction

    function automatic logic [XLEN-1:0] pick_imm();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom();
        if (sel < 8)
            return $urandom_range(0, 31) - 16;
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t          ins;
        int unsigned     kind;
        int unsigned     sel;
        logic [XLEN-1:0] want_addr;
        kind = $urandom_range(0, 99);
        ins  = make_instr(CMD_ADD, pick_reg(), pick_reg(), pick_reg(), pick_imm(),
                          $urandom_range(0, PROG_DEPTH - 1));
        if (kind < 38)
            ins.command = $urandom_range(CMD_ADD, CMD_XORI);
        else if (kind < 48)
            ins.command = CMD_LI;
        else if (kind < 62)
        begin
            ins.command = $urandom_range(CMD_BEQ, CMD_BGE);
            if ($urandom_range(0, 2) == 0)
                ins.src_reg_b = ins.src_reg_a;
        end
        else if (kind < 70)
            ins.command = $urandom_range(0, 1) ? CMD_JAL : CMD_JALR;
        else if (kind < 92)
        begin
            // Most accesses land in a few words so that loads see earlier stores.
            ins.command = $urandom_range(0, 1) ? CMD_LW : CMD_SW;
            sel = $urandom_range(0, 99);
            if (sel < 70)
                want_addr = $urandom_range(0, 31);
            else if (sel < 85)
                want_addr = $urandom_range(0, MEM_WORDS - 1);
            else if (sel < 90)
                want_addr = MEM_WORDS;
            else if (sel < 95)
                want_addr = 32'hFFFF_FFFF;
            else
                want_addr = $urandom() | (1 << MEM_AW);
            ins.immediate = imm_to_reach((ins.command == CMD_LW) ? ins.src_reg_a
                                                                  : ins.src_reg_b, want_addr);
        end
        else
            ins.command = $urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST);
        return ins;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_REPORTS)
            $display("mismatch in %s at result %0d: got %h, expected %h",
                     what, checked_count, got, want);
        error_count++;
    endtask

    task automatic check_retire(input logic [OUT_DATA_W-1:0] beat);
        retire_t got;
        retire_t want;
        got = beat[RETIRE_W-1:0];
        if (retire_q.size() == 0)
        begin
            report_mismatch("unexpected beat", beat, '0);
            return;
        end
        want = retire_q.pop_front();
        checked_count++;
        if (got.next_pc !== want.next_pc)
            report_mismatch("next_pc", got.next_pc, want.next_pc);
        if (got.halted !== want.halted)
            report_mismatch("halted", got.halted, want.halted);
        if (got.reg_write !== want.reg_write)
            report_mismatch("reg_write", got.reg_write, want.reg_write);
        if (got.write_index !== want.write_index)
            report_mismatch("write_index", got.write_index, want.write_index);
        if (got.write_value !== want.write_value)
            report_mismatch("write_value", got.write_value, want.write_value);
        if (got.mem_write !== want.mem_write)
            report_mismatch("mem_write", got.mem_write, want.mem_write);
        if (got.mem_address !== want.mem_address)
            report_mismatch("mem_address", got.mem_address, want.mem_address);
        if (got.bad_address !== want.bad_address)
            report_mismatch("bad_address", got.bad_address, want.bad_address);
        if (beat[OUT_DATA_W-1:RETIRE_W] !== '0)
            report_mismatch("padding", beat[OUT_DATA_W-1:RETIRE_W], '0);
    endtask

    // Receiver: checks every accepted beat, then chooses tready for the next cycle.
    always @(posedge clk)
    begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            check_retire(m_axis_tdata);
        sink_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_ALWAYS:  m_axis_tready <= 1'b1;
                SINK_PATTERN: m_axis_tready <= (sink_cycle % 4 != 3);
                default:
                begin
                    if ($urandom_range(0, 99) < 25)
                    begin
                        stall_left = $urandom_range(0, 5);
                        m_axis_tready <= 1'b0;
                    end
                    else
                        m_axis_tready <= 1'b1;
                end
            endcase
        end
    end

    // Offers one beat and records its expected result once it has been taken.
    task automatic send_instr(input instr_t ins);
        int unsigned gap;
        retire_t     expected;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            if (!stream_mode)
            begin
                gap = $urandom_range(1, GAP_MAX);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {{(IN_DATA_W-INSTR_W){1'b0}}, ins};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        expected = execute_instr(ins);
        retire_q = {retire_q, expected};
        sent_count++;
    endtask

    task automatic wait_all_retired();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (retire_q.size() != 0);
    endtask

    // Operand extremes, signed compares, wrap, shifts by the low five bits, a write to
    // register 0 and an unused command.
    task automatic test_alu_ops();
        send_instr(make_instr(CMD_LI,   1, 0, 0, 32'h7FFF_FFFF, 0));
        send_instr(make_instr(CMD_LI,   2, 0, 0, 32'h8000_0000, 0));
        send_instr(make_instr(CMD_LI,   3, 0, 0, 32'hFFFF_FFFF, 0));
        send_instr(make_instr(CMD_ADDI, 4, 3, 0, 32'h0000_0001, 0));
        send_instr(make_instr(CMD_ADD,  5, 1, 1, 0, 0));
        send_instr(make_instr(CMD_SUB,  6, 2, 1, 0, 0));
        send_instr(make_instr(CMD_SLT,  7, 2, 1, 0, 0));
        send_instr(make_instr(CMD_SLTI, 8, 1, 0, 32'hFFFF_FFFF, 0));
        send_instr(make_instr(CMD_SLL,  9, 3, 3, 0, 0));
        send_instr(make_instr(CMD_SRL, 10, 3, 3, 0, 0));
        send_instr(make_instr(CMD_AND, 11, 1, 3, 0, 0));
        send_instr(make_instr(CMD_OR,  12, 1, 2, 0, 0));
        send_instr(make_instr(CMD_XOR, 13, 3, 1, 0, 0));
        send_instr(make_instr(CMD_ANDI, 14, 3, 0, 32'h8000_0000, 0));
        send_instr(make_instr(CMD_XORI, 16, 2, 0, 32'hFFFF_FFFF, 0));
        send_instr(make_instr(CMD_ORI,  0, 0, 0, 32'h7FFF_FFFF, 0));
        send_instr(make_instr(CMD_UNUSED_FIRST, 31, 31, 31, 32'hFFFF_FFFF, 10'h3FF));
    endtask

    // Taken and untaken branches, a link from the top index and index wrap both ways.
    task automatic test_branches_jumps();
        send_instr(make_instr(CMD_BEQ,  0, 3, 3, 0, PROG_DEPTH - 1));
        send_instr(make_instr(CMD_JAL, 17, 0, 0, 32'd2, 0));
        send_instr(make_instr(CMD_BNE,  0, 1, 2, 0, 0));
        send_instr(make_instr(CMD_BLT,  0, 2, 1, 0, 512));
        send_instr(make_instr(CMD_BGE,  0, 2, 1, 0, 700));
        send_instr(make_instr(CMD_JAL, 18, 0, 0, -32'sd1000, 0));
        send_instr(make_instr(CMD_JALR, 19, 1, 0, 32'd1, 0));
    endtask

    // A store and load at the top word, then one address past the end and one negative.
    task automatic test_load_store();
        send_instr(make_instr(CMD_SW, 0, 1, 6, imm_to_reach(6, MEM_WORDS - 1), 0));
        send_instr(make_instr(CMD_LW, 20, 4, 0, imm_to_reach(4, MEM_WORDS - 1), 0));
        send_instr(make_instr(CMD_SW, 0, 3, 7, imm_to_reach(7, MEM_WORDS), 0));
        send_instr(make_instr(CMD_LW, 21, 2, 0, 32'd0, 0));
    endtask

    task automatic test_random_program();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0:       sink_mode = SINK_RANDOM;
                1:       sink_mode = SINK_PATTERN;
                default: sink_mode = SINK_ALWAYS;
            endcase
            burst_max   = (phase == 2) ? 64 : 16;
            stream_mode = (phase == 5);
            repeat (RANDOM_ITEMS / 6) send_instr(random_instr());
            if (phase == 3)
                wait_all_retired();
        end
        stream_mode = 1'b0;
        sink_mode   = SINK_RANDOM;
    endtask

    // The receiver holds off on its own count while beats keep coming, so the
    // pipeline fills and the input stalls; then the sender waits for every result.
    task automatic test_backpressure();
        wait_all_retired();
        stream_mode = 1'b1;
        hold_left   = HOLD_CYCLES;
        repeat (HOLD_ITEMS) send_instr(random_instr());
        stream_mode = 1'b0;
        wait_all_retired();
    endtask

    // EXIT has to come last: after it every instruction is ignored for the rest of the run.
    task automatic test_exit_halt();
        send_instr(make_instr(CMD_EXIT, 0, 0, 0, 0, 0));
        repeat (HALTED_ITEMS) send_instr(random_instr());
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_alu_ops();
        test_branches_jumps();
        test_load_store();
        wait_all_retired();
        test_random_program();
        test_backpressure();
        test_exit_halt();
        wait_all_retired();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d instructions and checked %0d results: %0d taken branches, %0d loads,",
                 sent_count, checked_count, taken_count, load_count);
        $display("%0d stores, %0d bad addresses, a %0d-cycle receiver hold and a final halt.",
                 store_count, bad_count, HOLD_CYCLES);
        if (error_count == 0 && retire_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### integer_execute_stage_top.f
+incdir+rtl
rtl/iexs_pkg.sv
rtl/iexs_ram.sv
rtl/iexs_exec.sv
rtl/integer_execute_stage_top.sv
rtl/iexs_checker.sv
bench/testbench.sv
